### rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg: shared types and constants of the positional list engine
// Holds the item codes, the status codes, the controller states and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ple_pkg;

	localparam int CAPACITY_DEF = 32;

	localparam int KIND_W     = 2;
	localparam int VALUE_W    = 32;
	localparam int POSITION_W = 6;
	localparam int STATUS_W   = 2;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT   = 2'd0,
		KIND_DELETE   = 2'd1,
		KIND_TRAVERSE = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_INS_CHK,
		S_INS_WR,
		S_DEL_CHK,
		S_DEL_WR,
		S_TRV_RD,
		S_TRV_LD,
		S_RESP
	} state_t;

	typedef enum logic [2:0] {
		IDX_HOLD,
		IDX_LEN,
		IDX_POS,
		IDX_ZERO,
		IDX_INC,
		IDX_DEC
	} idx_op_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_PREV,
		RD_NEXT,
		RD_CUR
	} rd_op_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_SHIFT,
		WR_VALUE
	} wr_op_t;

	typedef enum logic [1:0] {
		LEN_HOLD,
		LEN_INC,
		LEN_DEC
	} len_op_t;

	typedef struct packed {
		logic    latch;
		idx_op_t idx_op;
		rd_op_t  rd_op;
		wr_op_t  wr_op;
		len_op_t len_op;
		logic    out_load;
		status_t out_status;
		logic    out_trav;
	} dp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              ins_full;
		logic              ins_bad;
		logic              del_empty;
		logic              del_bad;
		logic              len_zero;
		logic              ins_more;
		logic              del_more;
		logic              trav_last;
		logic              out_free;
	} dp_sts_t;

endpackage

### rtl/ple_in_if.sv
// ----------------------------------------------------------------------------
// ple_in_if: request channel of the positional list engine
// Carries one edit or traverse request item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ple_in_if
	import ple_pkg::*;
	;
	logic                         valid;
	logic                         ready;
	logic        [KIND_W-1:0]     kind;
	logic signed [VALUE_W-1:0]    value;
	logic        [POSITION_W-1:0] position;

	modport source (output valid, kind, value, position, input ready);
	modport sink   (input valid, kind, value, position, output ready);
endinterface

### rtl/ple_out_if.sv
// ----------------------------------------------------------------------------
// ple_out_if: response channel of the positional list engine
// Carries one status or element item with a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ple_out_if
	import ple_pkg::*;
	;
	logic                      valid;
	logic                      ready;
	logic        [STATUS_W-1:0] status;
	logic signed [VALUE_W-1:0]  element;
	logic                      last;

	modport source (output valid, status, element, last, input ready);
	modport sink   (input valid, status, element, last, output ready);
endinterface

### rtl/ple_ram.sv
// ----------------------------------------------------------------------------
// ple_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/ple_dp.sv
// ----------------------------------------------------------------------------
// ple_dp: datapath of the positional list engine
// Request registers, list length, slot index, element store and the
// response register; raises the flags the controller branches on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_dp
	import ple_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dp_cmd_t                      cmd,
	output dp_sts_t                      sts,
	input  logic        [KIND_W-1:0]     in_kind,
	input  logic signed [VALUE_W-1:0]    in_value,
	input  logic        [POSITION_W-1:0] in_position,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic        [STATUS_W-1:0]   out_status,
	output logic signed [VALUE_W-1:0]    out_element,
	output logic                         out_last
);
	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = ((LW > POSITION_W) ? LW : POSITION_W) + 1;

	logic        [KIND_W-1:0]     kind_q;
	logic signed [VALUE_W-1:0]    value_q;
	logic        [POSITION_W-1:0] pos_q;
	logic        [LW-1:0]         len_q;
	logic        [AW-1:0]         idx_q;

	logic                         out_valid_q;
	logic        [STATUS_W-1:0]   out_status_q;
	logic signed [VALUE_W-1:0]    out_element_q;
	logic                         out_last_q;

	logic        [CW-1:0]         pos_ext, len_ext, idx_ext;
	logic                         ram_we, ram_re;
	logic        [AW-1:0]         ram_waddr, ram_raddr;
	logic        [VALUE_W-1:0]    ram_wdata, ram_rdata;

	assign pos_ext = CW'(pos_q);
	assign len_ext = CW'(len_q);
	assign idx_ext = CW'(idx_q);

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q  <= in_kind;
			value_q <= in_value;
			pos_q   <= in_position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else begin
			case (cmd.len_op)
				LEN_INC: len_q <= len_q + LW'(1);
				LEN_DEC: len_q <= len_q - LW'(1);
				default: len_q <= len_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.idx_op)
			IDX_LEN:  idx_q <= AW'(len_q);
			IDX_POS:  idx_q <= AW'(pos_ext - CW'(1));
			IDX_ZERO: idx_q <= '0;
			IDX_INC:  idx_q <= idx_q + AW'(1);
			IDX_DEC:  idx_q <= idx_q - AW'(1);
			default:  idx_q <= idx_q;
		endcase
	end

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		case (cmd.rd_op)
			RD_PREV: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q - AW'(1);
			end
			RD_NEXT: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q + AW'(1);
			end
			RD_CUR: begin
				ram_re    = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		case (cmd.wr_op)
			WR_SHIFT: begin
				ram_we = 1'b1;
			end
			WR_VALUE: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(pos_ext - CW'(1));
				ram_wdata = value_q;
			end
			default: ;
		endcase
	end

	ple_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q  <= cmd.out_status;
			out_element_q <= cmd.out_trav ? ram_rdata : '0;
			out_last_q    <= cmd.out_trav ? sts.trav_last : 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_status  = out_status_q;
	assign out_element = out_element_q;
	assign out_last    = out_last_q;

	always_comb begin
		sts.kind      = kind_q;
		sts.ins_full  = len_ext >= CW'(CAPACITY);
		sts.ins_bad   = (pos_q == '0) || (pos_ext > len_ext + CW'(1));
		sts.del_empty = len_q == '0;
		sts.del_bad   = (pos_q == '0) || (pos_ext > len_ext);
		sts.len_zero  = len_q == '0;
		sts.ins_more  = idx_ext >= pos_ext;
		sts.del_more  = (idx_ext + CW'(1)) < len_ext;
		sts.trav_last = (idx_ext + CW'(1)) == len_ext;
		sts.out_free  = !out_valid_q || out_ready;
	end
endmodule

### rtl/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl: controller of the positional list engine
// Sequences decode, element shifts, traverse reads and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_ctrl
	import ple_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	state_t  state_q, state_d;
	status_t resp_q, resp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			resp_q  <= STAT_OK;
		end else begin
			state_q <= state_d;
			resp_q  <= resp_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		resp_d         = resp_q;
		in_ready       = 1'b0;
		cmd.latch      = 1'b0;
		cmd.idx_op     = IDX_HOLD;
		cmd.rd_op      = RD_NONE;
		cmd.wr_op      = WR_NONE;
		cmd.len_op     = LEN_HOLD;
		cmd.out_load   = 1'b0;
		cmd.out_status = resp_q;
		cmd.out_trav   = 1'b0;

		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.kind)
					KIND_INSERT: begin
						if (sts.ins_full) begin
							resp_d  = STAT_FULL;
							state_d = S_RESP;
						end else if (sts.ins_bad) begin
							resp_d  = STAT_BADPOS;
							state_d = S_RESP;
						end else begin
							cmd.idx_op = IDX_LEN;
							state_d    = S_INS_CHK;
						end
					end
					KIND_DELETE: begin
						if (sts.del_empty) begin
							resp_d  = STAT_EMPTY;
							state_d = S_RESP;
						end else if (sts.del_bad) begin
							resp_d  = STAT_BADPOS;
							state_d = S_RESP;
						end else begin
							cmd.idx_op = IDX_POS;
							state_d    = S_DEL_CHK;
						end
					end
					KIND_TRAVERSE: begin
						if (sts.len_zero) begin
							resp_d  = STAT_EMPTY;
							state_d = S_RESP;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d    = S_TRV_RD;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_INS_CHK: begin
				if (sts.ins_more) begin
					cmd.rd_op = RD_PREV;
					state_d   = S_INS_WR;
				end else begin
					cmd.wr_op  = WR_VALUE;
					cmd.len_op = LEN_INC;
					resp_d     = STAT_OK;
					state_d    = S_RESP;
				end
			end
			S_INS_WR: begin
				cmd.wr_op  = WR_SHIFT;
				cmd.idx_op = IDX_DEC;
				state_d    = S_INS_CHK;
			end
			S_DEL_CHK: begin
				if (sts.del_more) begin
					cmd.rd_op = RD_NEXT;
					state_d   = S_DEL_WR;
				end else begin
					cmd.len_op = LEN_DEC;
					resp_d     = STAT_OK;
					state_d    = S_RESP;
				end
			end
			S_DEL_WR: begin
				cmd.wr_op  = WR_SHIFT;
				cmd.idx_op = IDX_INC;
				state_d    = S_DEL_CHK;
			end
			S_TRV_RD: begin
				// read only once the response register is sure to be free
				if (sts.out_free) begin
					cmd.rd_op = RD_CUR;
					state_d   = S_TRV_LD;
				end
			end
			S_TRV_LD: begin
				cmd.out_load   = 1'b1;
				cmd.out_status = STAT_OK;
				cmd.out_trav   = 1'b1;
				if (sts.trav_last) begin
					state_d = S_IDLE;
				end else begin
					cmd.idx_op = IDX_INC;
					state_d    = S_TRV_RD;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

### rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine: bounded ordered list edited by 1-based position
// An accepted insert or delete moves each shifted element with one store read
// and one store write; a rejected edit or empty traverse skips the store.
// Traverse: each element takes one store read and one response load, set by
// the single read port of the store, and waits until the response register is free.
// The next item can be taken in the cycle after the last response loads.
// Reset clears length and control; the store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_engine
	import ple_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ple_in_if.sink     req,
	ple_out_if.source  rsp
);
	// Structure
	//   ple_ctrl decodes each request item and steps through it:
	//     insert   - walk the index down from length to position, moving each
	//                element up one slot (a store read, then a write of that data),
	//                then drop the new value into its slot;
	//     delete   - walk the index up from position, moving each element
	//                down one slot, then shrink the length;
	//     traverse - read slot by slot and hand each element out, marking
	//                the final one.
	//   ple_dp holds the request, the length, the slot index, the element
	//   store and the response register, and flags the branch conditions.
	// Error checks follow the list rules: full before position on insert,
	// empty before position on delete. An unused kind gives no response.

	dp_cmd_t cmd;
	dp_sts_t sts;

	ple_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ple_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_kind     (req.kind),
		.in_value    (req.value),
		.in_position (req.position),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_status  (rsp.status),
		.out_element (rsp.element),
		.out_last    (rsp.last)
	);

	// no store write while a new item can be taken
	a_no_write_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> (cmd.wr_op == WR_NONE))
		else $error("store written while accepting an item");

	// never overwrite a response that has not been taken
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("response register overwritten");

	// grow only a list that has room
	a_no_grow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.len_op == LEN_INC) |-> !sts.ins_full)
		else $error("length grown past capacity");

	// shrink only a list that holds elements
	a_no_shrink_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.len_op == LEN_DEC) |-> !sts.len_zero)
		else $error("length shrunk below zero");
endmodule
